// ----- hw/rtl/sos_biquad_lowpass_cascade_assert.svh -----
// assertion macros used by the checker file
`ifndef SOS_BIQUAD_LOWPASS_CASCADE_ASSERT_SVH
`define SOS_BIQUAD_LOWPASS_CASCADE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SBLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SBLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sblc_pkg.sv -----
package sblc_pkg;

    // default sizing
    localparam int NUM_CHANNELS_DEF = 10;
    localparam int NUM_SECTIONS_DEF = 3;

    // fixed formats
    localparam int SMP_W   = 16;
    localparam int CH_W    = 4;
    localparam int ST_W    = 32;
    localparam int COEF_W  = 24;
    localparam int DIG_W   = 8;
    localparam int NDIG    = ST_W / DIG_W;
    localparam int PROD_W  = COEF_W + ST_W;
    localparam int ACC_W   = 58;
    localparam int FRAC_C  = 20;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_W_A1,
        ST_W_A2,
        ST_W_RND,
        ST_Y_B0,
        ST_Y_B1,
        ST_Y_B2,
        ST_Y_RND,
        ST_FINAL
    } sblc_state_t;

    // coefficient selector
    typedef enum logic [2:0] {
        CF_B0,
        CF_B1,
        CF_B2,
        CF_A1,
        CF_A2
    } coef_sel_t;

    // command into the serial mac
    typedef struct packed {
        logic                     load;
        logic signed [ACC_W-1:0]  load_val;
        logic                     start;
        logic                     sub;
        logic signed [COEF_W-1:0] coef;
        logic signed [ST_W-1:0]   opnd;
    } mac_cmd_t;

    // status from the serial mac
    typedef struct packed {
        logic busy;
        logic done;
    } mac_stat_t;

    // q3.20 section coefficients, pass-through beyond the third section
    function automatic logic signed [COEF_W-1:0] coef_f(input logic [2:0] row,
                                                       input coef_sel_t sel);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (row)
            3'd0:
            begin
                case (sel)
                    CF_B0:   c = 24'sd1363;
                    CF_B1:   c = 24'sd1363;
                    CF_A1:   c = -24'sd534249;
                    default: c = '0;
                endcase
            end
            3'd1:
            begin
                case (sel)
                    CF_B0:   c = 24'sd1048576;
                    CF_B1:   c = 24'sd2098830;
                    CF_B2:   c = 24'sd1050254;
                    CF_A1:   c = -24'sd1149868;
                    CF_A2:   c = 24'sd372664;
                    default: c = '0;
                endcase
            end
            3'd2:
            begin
                case (sel)
                    CF_B0:   c = 24'sd1048576;
                    CF_B1:   c = 24'sd2096523;
                    CF_B2:   c = 24'sd1047947;
                    CF_A1:   c = -24'sd1435815;
                    CF_A2:   c = 24'sd726244;
                    default: c = '0;
                endcase
            end
            default:
            begin
                case (sel)
                    CF_B0:   c = 24'sd1048576;
                    default: c = '0;
                endcase
            end
        endcase
        return c;
    endfunction

    // round a q.36 sum to q15.16 and saturate to 32 bits
    function automatic logic signed [ST_W-1:0] to_state(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]        s;
        logic signed [ACC_W-FRAC_C-1:0] r;
        s = acc + ACC_W'(524288);
        r = s[ACC_W-1:FRAC_C];
        if (r[ACC_W-FRAC_C-1:ST_W-1] == '0 || r[ACC_W-FRAC_C-1:ST_W-1] == '1)
            return r[ST_W-1:0];
        else if (r[ACC_W-FRAC_C-1])
            return {1'b1, {(ST_W-1){1'b0}}};
        else
            return {1'b0, {(ST_W-1){1'b1}}};
    endfunction

endpackage

// ----- hw/rtl/sos_biquad_lowpass_cascade.sv -----
// Fifth-order Butterworth low-pass, one independent filter per channel, built
// from NUM_SECTIONS direct-form-II biquads in q15.16 with q3.20 coefficients.
// One item in gives one item out: the channel echoed, the filtered sample
// saturated to 16 bits and a clipped flag. A channel at or above NUM_CHANNELS
// passes its sample through untouched and changes no state. All multiplies go
// through one 24 x 8 bit digit-serial mac; one item is in work at a time, and
// the next is taken while the previous result still waits in the output
// register. After reset the delay memory is cleared, one entry a cycle,
// before the first item is taken.
module sos_biquad_lowpass_cascade
    import sblc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int NUM_SECTIONS = NUM_SECTIONS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic [CH_W-1:0]         channel,
    input  logic signed [SMP_W-1:0] sample,
    output logic                    result_valid,
    input  logic                    result_ready,
    output logic [CH_W-1:0]         out_channel,
    output logic signed [SMP_W-1:0] filtered,
    output logic                    clipped
);

    localparam int DEPTH  = NUM_CHANNELS * NUM_SECTIONS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SEC_W  = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

    sblc_state_t state_reg, state_next;
    logic                    issued_reg;
    logic [ADDR_W-1:0]       clr_cnt_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [SEC_W-1:0]        sec_reg;
    logic [CH_W-1:0]         ch_reg;
    logic signed [SMP_W-1:0] smp_reg;
    logic                    bypass_reg;
    logic signed [ST_W-1:0]  x_reg;
    logic signed [ST_W-1:0]  z1_reg;
    logic signed [ST_W-1:0]  z2_reg;
    logic signed [ST_W-1:0]  w_reg;
    logic                    res_valid_reg;
    logic [CH_W-1:0]         res_ch_reg;
    logic signed [SMP_W-1:0] res_val_reg;
    logic                    res_clip_reg;

    mac_cmd_t                cmd;
    mac_stat_t               stat;
    logic signed [ACC_W-1:0] acc;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [2*ST_W-1:0]       ram_wdata;
    logic [2*ST_W-1:0]       ram_rdata;

    logic                    accept;
    logic                    last_sec;
    logic                    out_free;
    logic signed [ST_W-1:0]  rnd_state;
    logic signed [ST_W:0]    fin_sum;
    logic signed [SMP_W:0]   fin_rnd;
    logic signed [SMP_W-1:0] fin_val;
    logic                    fin_clip;

    sblc_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .acc   (acc)
    );

    sblc_ram #(.WIDTH(2 * ST_W), .DEPTH(DEPTH)) u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign last_sec     = (sec_reg == SEC_W'(NUM_SECTIONS - 1));
    assign out_free     = !res_valid_reg || result_ready;
    assign rnd_state    = to_state(acc);

    // final rounding to an integer sample with saturation, or the raw sample on bypass
    always_comb
    begin
        fin_sum  = {x_reg[ST_W-1], x_reg} + (ST_W+1)'(32768);
        fin_rnd  = fin_sum[ST_W:ST_W-SMP_W];
        fin_clip = 1'b0;
        fin_val  = fin_rnd[SMP_W-1:0];
        if (bypass_reg)
            fin_val = smp_reg;
        else if (fin_rnd[SMP_W] != fin_rnd[SMP_W-1])
        begin
            fin_clip = 1'b1;
            fin_val  = fin_rnd[SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}}
                                      : {1'b0, {(SMP_W-1){1'b1}}};
        end
    end

    // sequencer: next state, mac commands and memory writes
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = {w_reg, z1_reg};
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = (channel >= NUM_CHANNELS) ? ST_FINAL : ST_READ;
            end
            ST_READ:
            begin
                cmd.load     = 1'b1;
                cmd.load_val = {{(ACC_W-ST_W-FRAC_C){x_reg[ST_W-1]}}, x_reg,
                                {FRAC_C{1'b0}}};
                state_next   = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_W_A1;
            end
            ST_W_A1:
            begin
                cmd.start = !issued_reg;
                cmd.sub   = 1'b1;
                cmd.coef  = coef_f(3'(sec_reg), CF_A1);
                cmd.opnd  = z1_reg;
                if (stat.done)
                    state_next = ST_W_A2;
            end
            ST_W_A2:
            begin
                cmd.start = !issued_reg;
                cmd.sub   = 1'b1;
                cmd.coef  = coef_f(3'(sec_reg), CF_A2);
                cmd.opnd  = z2_reg;
                if (stat.done)
                    state_next = ST_W_RND;
            end
            ST_W_RND:
            begin
                cmd.load   = 1'b1;
                state_next = ST_Y_B0;
            end
            ST_Y_B0:
            begin
                cmd.start = !issued_reg;
                cmd.coef  = coef_f(3'(sec_reg), CF_B0);
                cmd.opnd  = w_reg;
                if (stat.done)
                    state_next = ST_Y_B1;
            end
            ST_Y_B1:
            begin
                cmd.start = !issued_reg;
                cmd.coef  = coef_f(3'(sec_reg), CF_B1);
                cmd.opnd  = z1_reg;
                if (stat.done)
                    state_next = ST_Y_B2;
            end
            ST_Y_B2:
            begin
                cmd.start = !issued_reg;
                cmd.coef  = coef_f(3'(sec_reg), CF_B2);
                cmd.opnd  = z2_reg;
                if (stat.done)
                    state_next = ST_Y_RND;
            end
            ST_Y_RND:
            begin
                ram_we     = 1'b1;
                state_next = last_sec ? ST_FINAL : ST_READ;
            end
            ST_FINAL:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            issued_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.start)
                issued_reg <= 1'b1;
            else if (stat.done)
                issued_reg <= 1'b0;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == ST_FINAL && out_free)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg     <= channel;
            smp_reg    <= sample;
            bypass_reg <= (channel >= NUM_CHANNELS);
            x_reg      <= {sample, {(ST_W-SMP_W){1'b0}}};
            addr_reg   <= ADDR_W'(channel * NUM_SECTIONS);
            sec_reg    <= '0;
        end
        if (state_reg == ST_WAIT)
        begin
            z1_reg <= ram_rdata[2*ST_W-1:ST_W];
            z2_reg <= ram_rdata[ST_W-1:0];
        end
        if (state_reg == ST_W_RND)
            w_reg <= rnd_state;
        if (state_reg == ST_Y_RND)
        begin
            x_reg <= rnd_state;
            if (!last_sec)
            begin
                addr_reg <= addr_reg + 1'b1;
                sec_reg  <= sec_reg + 1'b1;
            end
        end
        if (state_reg == ST_FINAL && out_free)
        begin
            res_ch_reg   <= ch_reg;
            res_val_reg  <= fin_val;
            res_clip_reg <= fin_clip;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_channel  = res_ch_reg;
    assign filtered     = res_val_reg;
    assign clipped      = res_clip_reg;

endmodule

// ----- hw/rtl/sblc_ram.sv -----
module sblc_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 30,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/sblc_mac.sv -----
module sblc_mac
    import sblc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_cmd_t                cmd,
    output mac_stat_t               stat,
    output logic signed [ACC_W-1:0] acc
);

    localparam int CNT_W = $clog2(NDIG);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NDIG - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      sub_reg;
    logic signed [COEF_W-1:0]  coef_reg;
    logic [ST_W-1:0]           opnd_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    logic                           first;
    logic signed [DIG_W:0]          digit;
    logic signed [COEF_W+DIG_W:0]   dprod;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [ACC_W-1:0]        prod_ext;

    // top digit first: the leading digit is signed, the rest unsigned
    always_comb
    begin
        first     = (cnt_reg == '0);
        digit     = {first & opnd_reg[ST_W-1], opnd_reg[ST_W-1 -: DIG_W]};
        dprod     = coef_reg * digit;
        prod_next = (prod_reg <<< DIG_W)
                  + {{(PROD_W-COEF_W-DIG_W-1){dprod[COEF_W+DIG_W]}}, dprod};
        prod_ext  = {{(ACC_W-PROD_W){prod_next[PROD_W-1]}}, prod_next};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    // operand shift register, partial product and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            coef_reg <= cmd.coef;
            opnd_reg <= cmd.opnd;
            sub_reg  <= cmd.sub;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
            opnd_reg <= opnd_reg << DIG_W;
        end

        if (cmd.load)
            acc_reg <= cmd.load_val;
        else if (busy_reg && cnt_reg == CNT_LAST)
            acc_reg <= sub_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;

endmodule

// ----- hw/rtl/sblc_checker.sv -----
`include "sos_biquad_lowpass_cascade_assert.svh"

module sblc_checker
    import sblc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    sample_valid,
    input logic                    sample_ready,
    input logic [CH_W-1:0]         channel,
    input logic signed [SMP_W-1:0] sample,
    input logic                    result_valid,
    input logic                    result_ready,
    input logic [CH_W-1:0]         out_channel,
    input logic signed [SMP_W-1:0] filtered,
    input logic                    clipped
);

    // an item keeps the block busy: ready drops right after an item is taken
    `SBLC_ASSERT_NEXT(a_busy_after_item, sample_valid && sample_ready, !sample_ready, "ready right after an item")

    // a waiting input item holds
    `SBLC_ASSERT_NEXT(a_input_hold, sample_valid && !sample_ready, sample_valid && $stable(sample) && $stable(channel), "waiting input item changed")

    // a clipped result sits at a rail
    `SBLC_ASSERT_NOW(a_clip_rail, result_valid && clipped, filtered == 16'sh7fff || filtered == -16'sh8000, "clipped result not at a rail")

    // pass-through channels never clip
    `SBLC_ASSERT_NOW(a_bypass_noclip, result_valid && out_channel >= NUM_CHANNELS, !clipped, "bypass channel flagged clipped")

    // a stalled result holds
    `SBLC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(filtered) && $stable(out_channel), "stalled result changed")

endmodule

bind sos_biquad_lowpass_cascade sblc_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_sblc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .channel      (channel),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_channel  (out_channel),
    .filtered     (filtered),
    .clipped      (clipped)
);
